// File: hdl/complex_dot_product_mac_macros.svh
// Assertion macros for the complex dot product MAC.
// Needs i_clk and the active-low i_rst_n in the scope of the including module.
`ifndef COMPLEX_DOT_PRODUCT_MAC_MACROS_SVH
`define COMPLEX_DOT_PRODUCT_MAC_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define CDP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdp assertion failed");

// Consequent checked in the cycle after the antecedent
`define CDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdp assertion failed");

`endif

// File: hdl/cdp_pkg.sv
// Shared widths and types for the complex dot product MAC.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdp_pkg;

    localparam int IN_W  = 32;
    localparam int ACC_W = 64;
    // three 64-bit signed terms summed exactly need two guard bits
    localparam int SUM_W = ACC_W + 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // registered products of one element pair, with its controls
    typedef struct packed {
        logic                    mode;
        logic                    last;
        logic signed [ACC_W-1:0] rr;
        logic signed [ACC_W-1:0] ii;
        logic signed [ACC_W-1:0] ir;
        logic signed [ACC_W-1:0] ri;
    } t_terms;

endpackage

`default_nettype wire

// File: hdl/cdp_if.sv
// Valid/ready stream interfaces for the element pairs and the results.
// Depends on cdp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdp_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [cdp_pkg::IN_W-1:0] x_real;
    logic signed [cdp_pkg::IN_W-1:0] x_imag;
    logic signed [cdp_pkg::IN_W-1:0] y_real;
    logic signed [cdp_pkg::IN_W-1:0] y_imag;
    logic                            last;

    modport source (output valid, x_real, x_imag, y_real, y_imag, last, input ready);
    modport sink   (input valid, x_real, x_imag, y_real, y_imag, last, output ready);
endinterface

interface cdp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [cdp_pkg::ACC_W-1:0] dot_real;
    logic signed [cdp_pkg::ACC_W-1:0] dot_imag;
    logic                             saturated;

    modport source (output valid, dot_real, dot_imag, saturated, input ready);
    modport sink   (input valid, dot_real, dot_imag, saturated, output ready);
endinterface

`default_nettype wire

// File: hdl/cdp_mult.sv
// Product stage: four signed 32x32 multiplies registered per element pair.
// Depends on cdp_pkg and cdp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module cdp_mult (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    cdp_in_if.sink             i_in_chan,
    input  wire logic          i_mode,
    input  wire logic          i_s1_adv,
    output cdp_pkg::t_terms    o_terms,
    output logic               o_s1_vld
);

    logic            r_vld;
    cdp_pkg::t_terms r_terms;
    cdp_pkg::t_terms n_terms;
    logic            take;

    assign i_in_chan.ready = !r_vld || i_s1_adv;
    assign take            = i_in_chan.valid && i_in_chan.ready;

    always_comb begin
        n_terms.mode = i_mode;
        n_terms.last = i_in_chan.last;
        n_terms.rr   = i_in_chan.x_real * i_in_chan.y_real;
        n_terms.ii   = i_in_chan.x_imag * i_in_chan.y_imag;
        n_terms.ir   = i_in_chan.x_imag * i_in_chan.y_real;
        n_terms.ri   = i_in_chan.x_real * i_in_chan.y_imag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_s1_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms  = r_terms;
    assign o_s1_vld = r_vld;

endmodule

`default_nettype wire

// File: hdl/cdp_acc.sv
// Saturating accumulators, sticky clip flag and the result register.
// Depends on cdp_pkg, cdp_out_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "complex_dot_product_mac_macros.svh"

module cdp_acc (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s1_vld,
    input  cdp_pkg::t_terms    i_terms,
    output logic               o_s1_adv,
    cdp_out_if.source          o_out_chan
);

    logic signed [cdp_pkg::ACC_W-1:0] r_acc_real;
    logic signed [cdp_pkg::ACC_W-1:0] r_acc_imag;
    logic                             r_sticky;
    logic                             r_o_vld;
    logic signed [cdp_pkg::ACC_W-1:0] r_dot_real;
    logic signed [cdp_pkg::ACC_W-1:0] r_dot_imag;
    logic                             r_dot_sat;

    logic signed [cdp_pkg::SUM_W-1:0] sum_real;
    logic signed [cdp_pkg::SUM_W-1:0] sum_imag;
    logic signed [cdp_pkg::ACC_W-1:0] n_acc_real;
    logic signed [cdp_pkg::ACC_W-1:0] n_acc_imag;
    logic                             clip_real;
    logic                             clip_imag;
    logic                             clip;
    logic                             fin;

    always_comb begin
        sum_real = cdp_pkg::SUM_W'(i_terms.rr) + cdp_pkg::SUM_W'(r_acc_real)
                 + (i_terms.mode ? cdp_pkg::SUM_W'(i_terms.ii) : '0);
        sum_imag = cdp_pkg::SUM_W'(r_acc_imag) + cdp_pkg::SUM_W'(i_terms.ir)
                 - cdp_pkg::SUM_W'(i_terms.ri);

        // out of range when the top three bits disagree
        clip_real = !(sum_real[cdp_pkg::SUM_W-1:cdp_pkg::ACC_W-1] == 3'b000 ||
                      sum_real[cdp_pkg::SUM_W-1:cdp_pkg::ACC_W-1] == 3'b111);
        clip_imag = i_terms.mode &&
                    !(sum_imag[cdp_pkg::SUM_W-1:cdp_pkg::ACC_W-1] == 3'b000 ||
                      sum_imag[cdp_pkg::SUM_W-1:cdp_pkg::ACC_W-1] == 3'b111);

        if (clip_real) begin
            n_acc_real = sum_real[cdp_pkg::SUM_W-1] ? cdp_pkg::ACC_MIN : cdp_pkg::ACC_MAX;
        end else begin
            n_acc_real = sum_real[cdp_pkg::ACC_W-1:0];
        end

        // real mode leaves the imaginary sum untouched
        if (!i_terms.mode) begin
            n_acc_imag = r_acc_imag;
        end else if (clip_imag) begin
            n_acc_imag = sum_imag[cdp_pkg::SUM_W-1] ? cdp_pkg::ACC_MIN : cdp_pkg::ACC_MAX;
        end else begin
            n_acc_imag = sum_imag[cdp_pkg::ACC_W-1:0];
        end

        clip = clip_real || clip_imag;
    end

    // a last request waits only while an unread result sits in the output register
    assign o_s1_adv = i_s1_vld && (!i_terms.last || !r_o_vld || o_out_chan.ready);
    assign fin      = o_s1_adv && i_terms.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_real <= '0;
            r_acc_imag <= '0;
            r_sticky   <= 1'b0;
        end else if (fin) begin
            r_acc_real <= '0;
            r_acc_imag <= '0;
            r_sticky   <= 1'b0;
        end else if (o_s1_adv) begin
            r_acc_real <= n_acc_real;
            r_acc_imag <= n_acc_imag;
            r_sticky   <= r_sticky || clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (fin) begin
            r_o_vld <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_dot_real <= n_acc_real;
            r_dot_imag <= i_terms.mode ? n_acc_imag : '0;
            r_dot_sat  <= r_sticky || clip;
        end
    end

    assign o_out_chan.valid     = r_o_vld;
    assign o_out_chan.dot_real  = r_dot_real;
    assign o_out_chan.dot_imag  = r_dot_imag;
    assign o_out_chan.saturated = r_dot_sat;

    `CDP_ASSERT_NEXT(a_clear_after_last, fin, r_acc_real == '0 && r_acc_imag == '0 && !r_sticky)
    `CDP_ASSERT_NEXT(a_result_follows_last, fin, o_out_chan.valid)
    `CDP_ASSERT_NEXT(a_clip_reported, fin && clip, o_out_chan.saturated)
    `CDP_ASSERT_SAME(a_no_overwrite, fin && r_o_vld, o_out_chan.ready)

endmodule

`default_nettype wire

// File: hdl/complex_dot_product_mac.sv
// Complex dot product MAC: one element pair accepted per cycle while no stall holds.
// A request marked last passes the product register and then the result
// register, whose valid flag marks the finished dot product.
// A stalled result holds only a request marked last, and new input waits behind it; others keep flowing.
// Synchronous active-low reset clears complex_mode, the accumulators, the
// sticky flag and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module complex_dot_product_mac (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    cdp_in_if.sink    i_in_chan,
    cdp_out_if.source o_out_chan
);

    logic            r_complex_mode;
    cdp_pkg::t_terms terms;
    logic            s1_vld;
    logic            s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complex_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_complex_mode <= i_cfg_data;
        end
    end

    cdp_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_chan (i_in_chan),
        .i_mode    (r_complex_mode),
        .i_s1_adv  (s1_adv),
        .o_terms   (terms),
        .o_s1_vld  (s1_vld)
    );

    cdp_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_vld   (s1_vld),
        .i_terms    (terms),
        .o_s1_adv   (s1_adv),
        .o_out_chan (o_out_chan)
    );

endmodule

`default_nettype wire
